// ===== sv/ncomix_pkg.sv =====
`default_nettype none

package ncomix_pkg;

    localparam int SAMPLE_WIDTH_DEF      = 16;
    localparam int PHASE_LOOKUP_BITS_DEF = 12;

    // phase accumulator and increment register
    localparam int PHASE_WIDTH = 32;

    // rotator magnitude, unsigned Q1.16, 0 .. 65536
    localparam int COEF_WIDTH = 17;
    localparam int ONE_Q16    = 65536;

    // fraction bits dropped from each product sum
    localparam int PROD_FRAC = 16;

    // quadrant signs of the looked-up sine and cosine
    typedef struct packed {
        logic sin_neg;
        logic cos_neg;
    } coef_sign_t;

endpackage

`default_nettype wire

// ===== sv/nco_downconvert_mixer_top.sv =====
`default_nettype none

// NCO down-conversion mixer: multiplies each complex sample by exp(j*phase)
// and steps the 32-bit phase back by phase_increment per sample.
// Input channel: sample_valid / sample_stall with sample_i, sample_q.
// Result channel: result_valid / result_stall with out_i, out_q, one word
// per input word, in order.
// Config: cfg_we writes cfg_wdata into phase_increment; write only while idle.
// An increment of zero passes samples through unchanged and holds the phase.
// Each word passes four registered cells (phase index, sine ROM read,
// multiply, round/saturate). Throughput: one word per cycle while no output
// word is held by result_stall, as the four cells advance as a whole.
// When result_stall holds a waiting word, the whole chain freezes and
// sample_stall goes high in the same cycle; bubbles ahead of the output
// are held too.
// Reset clears the phase, the increment and all valid bits; no ROM init pass.
module nco_downconvert_mixer_top #(
    parameter int SAMPLE_WIDTH      = ncomix_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_LOOKUP_BITS = ncomix_pkg::PHASE_LOOKUP_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ncomix_pkg::PHASE_WIDTH-1:0]  cfg_wdata,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_q,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]           out_i,
    output logic signed [SAMPLE_WIDTH-1:0]           out_q
);

    import ncomix_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int PB   = PHASE_LOOKUP_BITS;
    localparam int CW   = COEF_WIDTH + 1;
    localparam int PW   = SW + CW;
    localparam int SUMW = PW + 1;
    localparam int RW   = SUMW - PROD_FRAC;
    localparam int W1   = 2 * SW + PB + 1;
    localparam int W2   = 2 * SW + 1;
    localparam int W3   = 4 * PW + 2 * SW + 1;
    localparam int W4   = 2 * SW;

    localparam logic [PHASE_WIDTH-1:0] PHASE_HALF_STEP =
        PHASE_WIDTH'(64'd1 << (PHASE_WIDTH - 1 - PB));
    localparam logic [PB-1:0] QUARTER_TURN = PB'(64'd1 << (PB - 2));
    localparam logic signed [SUMW-1:0] ROUND_HALF = SUMW'(64'd1 << (PROD_FRAC - 1));
    localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-(64'sd1 <<< (SW - 1)));

    logic                   advance;
    logic                   accept;
    logic [PHASE_WIDTH-1:0] inc_reg;
    logic [PHASE_WIDTH-1:0] acc_reg;
    logic [PHASE_WIDTH-1:0] acc_next;
    logic [PHASE_WIDTH-1:0] phase_round;
    logic                   bypass0;

    // whole chain moves unless a finished word is held at the output
    assign advance      = !result_valid || !result_stall;
    assign sample_stall = !advance;
    assign accept       = sample_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                inc_reg <= cfg_wdata;
            end
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        bypass0     = (inc_reg == '0);
        phase_round = acc_reg + PHASE_HALF_STEP;
        acc_next    = (accept && !bypass0) ? acc_reg - inc_reg : acc_reg;
    end

    // cell 1: sample + rounded phase index
    logic          s1_valid;
    logic [W1-1:0] s1_data;
    logic [SW-1:0] s1_i;
    logic [SW-1:0] s1_q;
    logic [PB-1:0] s1_phase;
    logic          s1_bypass;

    ncomix_cell #(.WIDTH(W1)) u_cell1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (sample_valid),
        .data_in   ({sample_i, sample_q, phase_round[PHASE_WIDTH-1 -: PB], bypass0}),
        .valid_out (s1_valid),
        .data_out  (s1_data)
    );

    assign {s1_i, s1_q, s1_phase, s1_bypass} = s1_data;

    // cell 2: sine/cosine read, sample carried alongside
    logic                  s2_valid;
    logic [W2-1:0]         s2_data;
    logic [SW-1:0]         s2_i;
    logic [SW-1:0]         s2_q;
    logic                  s2_bypass;
    logic [COEF_WIDTH-1:0] s2_sin_mag;
    logic [COEF_WIDTH-1:0] s2_cos_mag;
    coef_sign_t            s2_sign;

    ncomix_sine_rom #(.PHASE_BITS(PB)) u_rom (
        .clk       (clk),
        .advance   (advance),
        .sin_phase (s1_phase),
        .cos_phase (s1_phase + QUARTER_TURN),
        .sin_mag   (s2_sin_mag),
        .cos_mag   (s2_cos_mag),
        .sign      (s2_sign)
    );

    ncomix_cell #(.WIDTH(W2)) u_cell2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (s1_valid),
        .data_in   ({s1_i, s1_q, s1_bypass}),
        .valid_out (s2_valid),
        .data_out  (s2_data)
    );

    assign {s2_i, s2_q, s2_bypass} = s2_data;

    logic signed [CW-1:0] coef_s;
    logic signed [CW-1:0] coef_c;
    logic signed [PW-1:0] prod_ic;
    logic signed [PW-1:0] prod_qs;
    logic signed [PW-1:0] prod_is;
    logic signed [PW-1:0] prod_qc;

    always_comb
    begin
        coef_s  = s2_sign.sin_neg ? -$signed({1'b0, s2_sin_mag}) : $signed({1'b0, s2_sin_mag});
        coef_c  = s2_sign.cos_neg ? -$signed({1'b0, s2_cos_mag}) : $signed({1'b0, s2_cos_mag});
        prod_ic = $signed(s2_i) * coef_c;
        prod_qs = $signed(s2_q) * coef_s;
        prod_is = $signed(s2_i) * coef_s;
        prod_qc = $signed(s2_q) * coef_c;
    end

    // cell 3: products
    logic          s3_valid;
    logic [W3-1:0] s3_data;
    logic [PW-1:0] s3_ic;
    logic [PW-1:0] s3_qs;
    logic [PW-1:0] s3_is;
    logic [PW-1:0] s3_qc;
    logic [SW-1:0] s3_i;
    logic [SW-1:0] s3_q;
    logic          s3_bypass;

    ncomix_cell #(.WIDTH(W3)) u_cell3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (s2_valid),
        .data_in   ({prod_ic, prod_qs, prod_is, prod_qc, s2_i, s2_q, s2_bypass}),
        .valid_out (s3_valid),
        .data_out  (s3_data)
    );

    assign {s3_ic, s3_qs, s3_is, s3_qc, s3_i, s3_q, s3_bypass} = s3_data;

    logic signed [SUMW-1:0] re_round;
    logic signed [SUMW-1:0] im_round;
    logic signed [RW-1:0]   re_scaled;
    logic signed [RW-1:0]   im_scaled;
    logic        [SW-1:0]   res_i;
    logic        [SW-1:0]   res_q;

    // round half up: add half an LSB, then drop the fraction (floor)
    always_comb
    begin
        re_round  = SUMW'($signed(s3_ic)) - SUMW'($signed(s3_qs)) + ROUND_HALF;
        im_round  = SUMW'($signed(s3_is)) + SUMW'($signed(s3_qc)) + ROUND_HALF;
        re_scaled = $signed(re_round[SUMW-1:PROD_FRAC]);
        im_scaled = $signed(im_round[SUMW-1:PROD_FRAC]);
        if (s3_bypass)
        begin
            res_i = s3_i;
            res_q = s3_q;
        end
        else
        begin
            if (re_scaled > SAT_MAX)
            begin
                res_i = SW'(SAT_MAX);
            end
            else if (re_scaled < SAT_MIN)
            begin
                res_i = SW'(SAT_MIN);
            end
            else
            begin
                res_i = SW'(re_scaled);
            end
            if (im_scaled > SAT_MAX)
            begin
                res_q = SW'(SAT_MAX);
            end
            else if (im_scaled < SAT_MIN)
            begin
                res_q = SW'(SAT_MIN);
            end
            else
            begin
                res_q = SW'(im_scaled);
            end
        end
    end

    // cell 4: output word
    logic [W4-1:0] s4_data;

    ncomix_cell #(.WIDTH(W4)) u_cell4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (s3_valid),
        .data_in   ({res_i, res_q}),
        .valid_out (result_valid),
        .data_out  (s4_data)
    );

    assign out_i = $signed(s4_data[W4-1:SW]);
    assign out_q = $signed(s4_data[SW-1:0]);

`ifndef SYNTHESIS
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> sample_stall)
        else $error("input taken while output word is held");

    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_valid && !sample_stall) |=> $stable(acc_reg))
        else $error("phase moved without an accepted word");

    a_phase_steps: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && inc_reg != '0
        |=> acc_reg == $past(acc_reg) - $past(inc_reg))
        else $error("phase did not step back by the increment");
`endif

endmodule

`default_nettype wire

// ===== sv/ncomix_cell.sv =====
`default_nettype none

module ncomix_cell #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             valid_in,
    input  wire logic [WIDTH-1:0] data_in,
    output logic                  valid_out,
    output logic      [WIDTH-1:0] data_out
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_in;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

// ===== sv/ncomix_sine_rom.sv =====
`default_nettype none

module ncomix_sine_rom #(
    parameter int PHASE_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              advance,
    input  wire logic [PHASE_BITS-1:0]             sin_phase,
    input  wire logic [PHASE_BITS-1:0]             cos_phase,
    output logic      [ncomix_pkg::COEF_WIDTH-1:0] sin_mag,
    output logic      [ncomix_pkg::COEF_WIDTH-1:0] cos_mag,
    output ncomix_pkg::coef_sign_t                 sign
);

    import ncomix_pkg::*;

    localparam int ADDR_W     = PHASE_BITS - 1;
    localparam int QUARTER    = 1 << (PHASE_BITS - 2);
    localparam int TABLE_BITS = (QUARTER + 1) * COEF_WIDTH;
    localparam logic [63:0] PI_Q46 = 64'h3243F6A8885A308D >> 14;

    // Quarter-wave sine, Q1.16, from a fixed-point Taylor series (Q2.30 inside)
    function automatic logic [TABLE_BITS-1:0] build_quarter();
        logic [TABLE_BITS-1:0] tbl;
        logic [63:0]           angle;
        logic [63:0]           term;
        longint                sum;
        tbl = '0;
        for (int k = 1; k < QUARTER; k++)
        begin
            angle = (64'(k) * PI_Q46 + (64'd1 << (14 + PHASE_BITS))) >> (15 + PHASE_BITS);
            term  = angle;
            sum   = longint'(angle);
            for (int n = 1; n <= 10; n++)
            begin
                term = (term * angle) >> 30;
                term = (term * angle) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + 64'sd8192) >>> 14;
            if (sum > ONE_Q16)
            begin
                sum = ONE_Q16;
            end
            tbl[k*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'(sum);
        end
        tbl[QUARTER*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'(ONE_Q16);
        return tbl;
    endfunction

    localparam logic [TABLE_BITS-1:0] ROM_DATA = build_quarter();

    logic [1:0]        sin_quad;
    logic [1:0]        cos_quad;
    logic [ADDR_W-1:0] sin_idx;
    logic [ADDR_W-1:0] cos_idx;

    logic [COEF_WIDTH-1:0] sin_mag_reg;
    logic [COEF_WIDTH-1:0] cos_mag_reg;
    coef_sign_t            sign_reg;

    // odd quadrants read the quarter table mirrored
    always_comb
    begin
        sin_quad = sin_phase[PHASE_BITS-1 -: 2];
        cos_quad = cos_phase[PHASE_BITS-1 -: 2];
        sin_idx  = sin_quad[0] ? ADDR_W'(QUARTER) - {1'b0, sin_phase[PHASE_BITS-3:0]}
                               : {1'b0, sin_phase[PHASE_BITS-3:0]};
        cos_idx  = cos_quad[0] ? ADDR_W'(QUARTER) - {1'b0, cos_phase[PHASE_BITS-3:0]}
                               : {1'b0, cos_phase[PHASE_BITS-3:0]};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_mag_reg      <= ROM_DATA[sin_idx*COEF_WIDTH +: COEF_WIDTH];
            cos_mag_reg      <= ROM_DATA[cos_idx*COEF_WIDTH +: COEF_WIDTH];
            sign_reg.sin_neg <= sin_quad[1];
            sign_reg.cos_neg <= cos_quad[1];
        end
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;
    assign sign    = sign_reg;

endmodule

`default_nettype wire

// ===== verif/tb_nco_downconvert_mixer_top.sv =====
`timescale 1ns / 1ps

module tb_nco_downconvert_mixer_top;

    localparam int SW    = ncomix_pkg::SAMPLE_WIDTH_DEF;
    localparam int LB    = ncomix_pkg::PHASE_LOOKUP_BITS_DEF;
    localparam int PW    = ncomix_pkg::PHASE_WIDTH;
    localparam int STEPS = 1 << LB;
    localparam int QTR   = STEPS / 4;
    localparam int IDLE_LIMIT = 4000;
    localparam longint unsigned PI_Q46 = 64'h3243F6A8885A308D >> 14;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t i;
        sample_t q;
    } iq_word_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          cfg_we       = 1'b0;
    logic [PW-1:0] cfg_wdata    = '0;
    logic          sample_valid = 1'b0;
    logic          sample_stall;
    sample_t       sample_i     = '0;
    sample_t       sample_q     = '0;
    logic          result_valid;
    logic          result_stall = 1'b0;
    sample_t       out_i;
    sample_t       out_q;

    // local copy of the mixer state
    int            sine_quarter [0:QTR];
    logic [PW-1:0] phase_step = '0;
    logic [PW-1:0] phase_acc  = '0;

    iq_word_t tx_pending [$];
    iq_word_t rotated_due [$];

    int words_in      = 0;
    int words_out     = 0;
    int mismatches    = 0;
    int clipped_words = 0;
    int bypass_words  = 0;
    int steps_written = 0;
    int idle_cycles   = 0;

    int burst_left = 0;
    int gap_left   = 0;
    iq_word_t head_word;

    int stall_tick   = 0;
    int stall_mode   = 0;
    int stall_period = 4;
    iq_word_t due_word;

    nco_downconvert_mixer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_i        (out_i),
        .out_q        (out_q)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int sine_lookup(input int unsigned p);
        int unsigned quad;
        int unsigned r;
        int          v;
        quad = (p >> (LB - 2)) & 3;
        r    = p & (QTR - 1);
        v    = (quad & 1) ? sine_quarter[QTR - r] : sine_quarter[r];
        return (quad & 2) ? -v : v;
    endfunction

    // divide by 2^16, round half up, clamp to the sample range
    function automatic sample_t round_to_sample(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > (2 ** (SW - 1)) - 1)
        begin
            r = (2 ** (SW - 1)) - 1;
            clipped_words++;
        end
        else if (r < -(2 ** (SW - 1)))
        begin
            r = -(2 ** (SW - 1));
            clipped_words++;
        end
        return sample_t'(r);
    endfunction

    function automatic void rotate_sample(input sample_t xi, input sample_t xq);
        logic [PW-1:0] rounded;
        int unsigned   idx;
        longint        c;
        longint        s;
        iq_word_t      w;
        if (phase_step == 0)
        begin
            // zero step: pass through, phase held
            w.i = xi;
            w.q = xq;
            bypass_words++;
        end
        else
        begin
            rounded   = phase_acc + (32'd1 << (31 - LB));
            idx       = rounded >> (32 - LB);
            s         = sine_lookup(idx);
            c         = sine_lookup((idx + QTR) & (STEPS - 1));
            w.i       = round_to_sample(longint'(xi) * c - longint'(xq) * s);
            w.q       = round_to_sample(longint'(xi) * s + longint'(xq) * c);
            phase_acc = phase_acc - phase_step;
        end
        rotated_due = {rotated_due, w};
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 15))
            0:       return sample_t'(-(2 ** (SW - 1)));
            1:       return sample_t'((2 ** (SW - 1)) - 1);
            2:       return sample_t'(0);
            3:       return sample_t'(-1);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic queue_word(input int xi, input int xq);
        iq_word_t w;
        w.i = sample_t'(xi);
        w.q = sample_t'(xq);
        tx_pending = {tx_pending, w};
    endtask

    // drain everything, let the pipe settle, then load a new step
    task automatic program_phase_step(input logic [PW-1:0] step);
        while (tx_pending.size() != 0 || sample_valid || rotated_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= step;
        @(posedge clk);
        cfg_we     <= 1'b0;
        phase_step = step;
        steps_written++;
        @(negedge clk);
    endtask

    // sender: bursts of words with random gaps in between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_i     <= '0;
            sample_q     <= '0;
            burst_left   = 0;
            gap_left     = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                rotate_sample(sample_i, sample_q);
                words_in++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if (tx_pending.size() > 0)
                begin
                    head_word    = tx_pending.pop_front();
                    sample_valid <= 1'b1;
                    sample_i     <= head_word.i;
                    sample_q     <= head_word.q;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // receiver: check each word, stall on a pattern picked anew at random whenever stall_tick wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_tick   = 0;
            stall_mode   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                words_out++;
                if (rotated_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word i=%0d q=%0d", $realtime, out_i, out_q);
                    mismatches++;
                end
                else
                begin
                    due_word = rotated_due.pop_front();
                    if (out_i !== due_word.i || out_q !== due_word.q)
                    begin
                        if (mismatches < 10)
                            $display("%0t: word %0d expected i=%0d q=%0d, got i=%0d q=%0d",
                                     $realtime, words_out - 1, due_word.i, due_word.q,
                                     out_i, out_q);
                        mismatches++;
                    end
                end
            end
            stall_tick = (stall_tick + 1) % 64;
            if (stall_tick == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                stall_period = $urandom_range(2, 9);
            end
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ((stall_tick % stall_period) == 0);
                default: result_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        longint unsigned k;
        longint unsigned n;
        longint unsigned ang;
        longint unsigned term;
        longint          acc_sum;
        int              n_items;
        logic [PW-1:0]   step;

        // quarter-wave sine, Q1.16, Taylor series in Q2.30
        sine_quarter[0]   = 0;
        sine_quarter[QTR] = 65536;
        for (k = 1; k < QTR; k++)
        begin
            ang     = (k * PI_Q46 + (64'd1 << (14 + LB))) >> (15 + LB);
            term    = ang;
            acc_sum = ang;
            for (n = 1; n <= 10; n++)
            begin
                term = (term * ang) >> 30;
                term = (term * ang) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n & 1)
                    acc_sum = acc_sum - longint'(term);
                else
                    acc_sum = acc_sum + longint'(term);
            end
            if (acc_sum < 0)
                acc_sum = 0;
            acc_sum = (acc_sum + 8192) >>> 14;
            if (acc_sum > 65536)
                acc_sum = 65536;
            sine_quarter[k] = int'(acc_sum);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero step: samples pass through untouched
        program_phase_step(32'h0000_0000);
        queue_word(-32768, -32768);
        queue_word(32767, 32767);
        queue_word(0, 0);
        queue_word(-32768, 32767);
        queue_word(32767, -32768);
        queue_word(16'shAAAA, 16'sh5555);
        queue_word(-1, 1);

        // 45 degree steps: full-scale corner saturates off-axis
        program_phase_step(32'h2000_0000);
        repeat (8) queue_word(-32768, -32768);
        queue_word(32767, 32767);
        queue_word(32767, -32768);

        // quarter-turn steps
        program_phase_step(32'h4000_0000);
        queue_word(-32768, 0);
        queue_word(0, -32768);
        queue_word(32767, -32768);
        queue_word(-32768, 32767);
        queue_word(1, -1);
        queue_word(-32768, -32768);

        for (int ph = 0; ph < 11; ph++)
        begin
            case (ph)
                0:       step = 32'h0000_0001;
                1:       step = 32'hFFFF_FFFF;
                2:       step = 32'h8000_0000;
                3:       step = 32'h0000_0000;    // bypass with a nonzero phase held
                4:       step = 32'h0008_0000;    // half a table step, hits the index rounding
                5:       step = $urandom_range(1, 65535);
                default: step = $urandom;
            endcase
            if (step == 0 && ph != 3)
                step = 32'h1234_5679;
            program_phase_step(step);
            n_items = $urandom_range(100, 130);
            repeat (n_items) queue_word(pick_sample(), pick_sample());
        end

        while (tx_pending.size() != 0 || sample_valid || rotated_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Mixed %0d samples (%0d passed through) under %0d phase steps;",
                 words_in, bypass_words, steps_written);
        $display("%0d output words clipped, %0d mismatches.", clipped_words, mismatches);
        if (mismatches == 0 && rotated_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ncomix_pkg.sv
sv/ncomix_cell.sv
sv/ncomix_sine_rom.sv
sv/nco_downconvert_mixer_top.sv
verif/tb_nco_downconvert_mixer_top.sv
